// ===== rtl/h264_rtp_depacketizer_macros.svh =====
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// during reset.
// ----------------------------------------------------------------------------
`ifndef H264_RTP_DEPACKETIZER_MACROS_SVH
`define H264_RTP_DEPACKETIZER_MACROS_SVH

// same-cycle implication
`define H264_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("h264 rtp depacketizer assertion failed");

// next-cycle implication
`define H264_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("h264 rtp depacketizer assertion failed");

`endif

// ===== rtl/h264rtp_pkg.sv =====
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer package
// Shared constants, error codes and the front-to-back command type.
// ----------------------------------------------------------------------------
`default_nettype none

package h264rtp_pkg;

    localparam int CMD_FIFO_DEPTH = 4;

    localparam int POS_W   = 4;
    localparam logic [POS_W-1:0] POS_HDR_END = 4'd12;
    localparam logic [POS_W-1:0] POS_FU_HDR  = 4'd13;
    localparam logic [POS_W-1:0] POS_SAT     = 4'd14;
    localparam logic [POS_W-1:0] POS_TS_LO   = 4'd4;
    localparam logic [POS_W-1:0] POS_TS_HI   = 4'd7;
    localparam logic [POS_W-1:0] POS_FLAGS   = 4'd1;
    localparam logic [POS_W-1:0] POS_FIRST   = 4'd0;

    localparam logic [7:0] VER_MASK   = 8'hc0;
    localparam logic [7:0] VER_TWO    = 8'h80;
    localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
    localparam logic [4:0] NAL_FU_A   = 5'd28;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_SHORT    = 2'd1;
    localparam logic [1:0] ERR_VERSION  = 2'd2;
    localparam logic [1:0] ERR_NAL_TYPE = 2'd3;

    typedef struct packed {
        logic        close_pre;
        logic        start_code;
        logic        fin;
        logic [7:0]  fin_byte;
        logic        fin_valid;
        logic        fin_end;
        logic [1:0]  fin_err;
        logic [31:0] old_ts;
        logic [31:0] ts;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/h264rtp_front.sv =====
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer front end
// Parses packet bytes, tracks header, timestamp and unit state, and issues
// at most one output command per accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module h264rtp_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    input  wire logic [7:0]          in_byte,
    input  wire logic                in_last,
    input  wire logic                cmd_ready,
    output h264rtp_pkg::cmd_t        cmd,
    output logic                     cmd_push
);

    logic [h264rtp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic        drop_reg, drop_next;
    logic        marker_reg, marker_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [31:0] last_ts_reg, last_ts_next;
    logic        open_reg, open_next;
    logic        kind_reg, kind_next;
    logic [1:0]  prio_reg, prio_next;
    logic        accept;
    logic [4:0]  nal_type;

    assign accept   = in_valid && cmd_ready;
    assign nal_type = in_byte[4:0];

    always_comb begin
        pos_next     = pos_reg;
        drop_next    = drop_reg;
        marker_next  = marker_reg;
        stamp_next   = stamp_reg;
        last_ts_next = last_ts_reg;
        open_next    = open_reg;
        kind_next    = kind_reg;
        prio_next    = prio_reg;
        cmd          = '0;
        cmd.old_ts   = last_ts_reg;

        if (pos_reg < h264rtp_pkg::POS_HDR_END) begin
            if (pos_reg == h264rtp_pkg::POS_FIRST) begin
                drop_next = (in_byte & h264rtp_pkg::VER_MASK) != h264rtp_pkg::VER_TWO;
            end
            if (pos_reg == h264rtp_pkg::POS_FLAGS) begin
                marker_next = in_byte[7];
            end
            if (pos_reg >= h264rtp_pkg::POS_TS_LO && pos_reg <= h264rtp_pkg::POS_TS_HI) begin
                stamp_next = {stamp_reg[23:0], in_byte};
            end
            if (in_last) begin
                cmd.fin     = 1'b1;
                cmd.fin_err = h264rtp_pkg::ERR_SHORT;
            end
        end else if (pos_reg == h264rtp_pkg::POS_HDR_END) begin
            if (drop_reg) begin
                cmd.fin     = 1'b1;
                cmd.fin_err = h264rtp_pkg::ERR_VERSION;
            end else begin
                if (stamp_reg != last_ts_reg) begin
                    if (open_reg) begin
                        cmd.close_pre = 1'b1;
                        open_next     = 1'b0;
                    end
                    last_ts_next = stamp_reg;
                end
                if (nal_type <= h264rtp_pkg::NAL_SINGLE_MAX) begin
                    kind_next      = 1'b0;
                    cmd.start_code = 1'b1;
                    cmd.fin        = 1'b1;
                    cmd.fin_byte   = in_byte;
                    cmd.fin_valid  = 1'b1;
                    cmd.fin_end    = in_last;
                    open_next      = !in_last;
                end else if (nal_type == h264rtp_pkg::NAL_FU_A) begin
                    kind_next = 1'b1;
                    prio_next = in_byte[6:5];
                    if (in_last) begin
                        cmd.fin     = 1'b1;
                        cmd.fin_err = h264rtp_pkg::ERR_SHORT;
                    end
                end else begin
                    drop_next   = 1'b1;
                    cmd.fin     = 1'b1;
                    cmd.fin_err = h264rtp_pkg::ERR_NAL_TYPE;
                end
            end
        end else if (!drop_reg) begin
            if (!kind_reg) begin
                cmd.fin       = 1'b1;
                cmd.fin_byte  = in_byte;
                cmd.fin_valid = 1'b1;
                cmd.fin_end   = in_last;
                open_next     = !in_last;
            end else if (pos_reg == h264rtp_pkg::POS_FU_HDR) begin
                if (in_byte[7] || !open_reg) begin
                    cmd.start_code = 1'b1;
                    cmd.fin        = 1'b1;
                    cmd.fin_byte   = {1'b0, prio_reg, in_byte[4:0]};
                    cmd.fin_valid  = 1'b1;
                    open_next      = 1'b1;
                end
                if (in_last && marker_reg) begin
                    cmd.fin     = 1'b1;
                    cmd.fin_end = 1'b1;
                    open_next   = 1'b0;
                end
            end else begin
                cmd.fin       = 1'b1;
                cmd.fin_byte  = in_byte;
                cmd.fin_valid = 1'b1;
                cmd.fin_end   = in_last && marker_reg;
                if (in_last && marker_reg) begin
                    open_next = 1'b0;
                end
            end
        end

        cmd.ts = last_ts_next;

        if (in_last) begin
            pos_next  = h264rtp_pkg::POS_FIRST;
            drop_next = 1'b0;
        end else if (pos_reg < h264rtp_pkg::POS_SAT) begin
            pos_next = pos_reg + 1'b1;
        end
    end

    assign cmd_push = accept && (cmd.close_pre || cmd.start_code || cmd.fin);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            drop_reg    <= 1'b0;
            marker_reg  <= 1'b0;
            stamp_reg   <= '0;
            last_ts_reg <= '0;
            open_reg    <= 1'b0;
            kind_reg    <= 1'b0;
            prio_reg    <= '0;
        end else if (accept) begin
            pos_reg     <= pos_next;
            drop_reg    <= drop_next;
            marker_reg  <= marker_next;
            stamp_reg   <= stamp_next;
            last_ts_reg <= last_ts_next;
            open_reg    <= open_next;
            kind_reg    <= kind_next;
            prio_reg    <= prio_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/h264rtp_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer command queue
// Short register queue that decouples the parser from the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "h264_rtp_depacketizer_macros.svh"

module h264rtp_cmd_fifo #(
    parameter int DEPTH = h264rtp_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire h264rtp_pkg::cmd_t push_cmd,
    output logic                   push_ready,
    input  wire logic              pop,
    output h264rtp_pkg::cmd_t      head_cmd,
    output logic                   head_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    h264rtp_pkg::cmd_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  do_push, do_pop;

    assign push_ready = count_reg != CNT_FULL;
    assign head_valid = count_reg != '0;
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `H264_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_FULL)
    `H264_ASSERT_NXT(a_count_up, aclk, aresetn, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)
    `H264_ASSERT_NXT(a_count_down, aclk, aresetn, do_pop && !do_push, count_reg == $past(count_reg) - 1'b1)

endmodule

`default_nettype wire

// ===== rtl/h264rtp_back.sv =====
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer output sequencer
// Expands each queued command into its result beats: unit close, start code,
// data or error, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "h264_rtp_depacketizer_macros.svh"

module h264rtp_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire h264rtp_pkg::cmd_t head_cmd,
    input  wire logic              head_valid,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [47:0]            m_tdata,
    output logic [2:0]             m_tuser,
    output logic                   m_tlast
);

    localparam logic [2:0] STEP_CLOSE = 3'd0;
    localparam logic [2:0] STEP_SC0   = 3'd1;
    localparam logic [2:0] STEP_SC1   = 3'd2;
    localparam logic [2:0] STEP_SC2   = 3'd3;
    localparam logic [2:0] STEP_SC3   = 3'd4;
    localparam logic [2:0] STEP_FIN   = 3'd5;

    logic [2:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [2:0]  cur_step, start_step, nstep;
    logic        has_next;
    logic        advance;

    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        bval_reg, bval_next;
    logic        end_reg, end_next;
    logic [31:0] ts_reg, ts_next;
    logic [1:0]  err_reg, err_next;
    logic        last_reg, last_next;

    assign advance    = !valid_reg || m_tready;
    assign start_step = head_cmd.close_pre ? STEP_CLOSE :
                        head_cmd.start_code ? STEP_SC0 : STEP_FIN;
    assign cur_step   = busy_reg ? step_reg : start_step;

    always_comb begin
        has_next = 1'b0;
        nstep    = STEP_FIN;
        case (cur_step)
            STEP_CLOSE: begin
                has_next = head_cmd.start_code || head_cmd.fin;
                nstep    = head_cmd.start_code ? STEP_SC0 : STEP_FIN;
            end
            STEP_SC0: begin
                has_next = 1'b1;
                nstep    = STEP_SC1;
            end
            STEP_SC1: begin
                has_next = 1'b1;
                nstep    = STEP_SC2;
            end
            STEP_SC2: begin
                has_next = 1'b1;
                nstep    = STEP_SC3;
            end
            STEP_SC3: begin
                has_next = head_cmd.fin;
                nstep    = STEP_FIN;
            end
            default: begin
                has_next = 1'b0;
                nstep    = STEP_FIN;
            end
        endcase
    end

    always_comb begin
        byte_next = 8'h00;
        bval_next = 1'b1;
        end_next  = 1'b0;
        ts_next   = head_cmd.ts;
        err_next  = h264rtp_pkg::ERR_NONE;
        case (cur_step)
            STEP_CLOSE: begin
                bval_next = 1'b0;
                end_next  = 1'b1;
                ts_next   = head_cmd.old_ts;
            end
            STEP_SC0, STEP_SC1, STEP_SC2: begin
                byte_next = 8'h00;
            end
            STEP_SC3: begin
                byte_next = 8'h01;
            end
            default: begin
                byte_next = head_cmd.fin_byte;
                bval_next = head_cmd.fin_valid;
                end_next  = head_cmd.fin_end;
                err_next  = head_cmd.fin_err;
            end
        endcase
        last_next = !has_next;
    end

    always_comb begin
        pop        = 1'b0;
        busy_next  = busy_reg;
        step_next  = step_reg;
        valid_next = valid_reg;
        if (advance) begin
            valid_next = head_valid;
            if (head_valid) begin
                pop       = !has_next;
                busy_next = has_next;
                step_next = nstep;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= STEP_CLOSE;
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && head_valid) begin
            byte_reg <= byte_next;
            bval_reg <= bval_next;
            end_reg  <= end_next;
            ts_reg   <= ts_next;
            err_reg  <= err_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, ts_reg, end_reg, byte_reg};
    assign m_tuser  = {err_reg, bval_reg};
    assign m_tlast  = last_reg;

    `H264_ASSERT_IMP(a_data_no_err, aclk, aresetn, valid_reg && bval_reg, err_reg == h264rtp_pkg::ERR_NONE)
    `H264_ASSERT_IMP(a_end_no_err, aclk, aresetn, valid_reg && end_reg, err_reg == h264rtp_pkg::ERR_NONE)
    `H264_ASSERT_IMP(a_err_is_last, aclk, aresetn, valid_reg && err_reg != h264rtp_pkg::ERR_NONE, last_reg)

endmodule

`default_nettype wire

// ===== rtl/h264_rtp_depacketizer.sv =====
// Path: each command is queued, then registered in the output stage.
// Throughput: one input beat per cycle while the command queue has room.
// Output: one result beat per cycle while the sink is ready; a byte that
// opens a NAL unit costs up to six result beats (unit close, four start-code
// bytes, data), set by the output sequencer.
// Reset: aresetn low clears parser state, queue and output stage.
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer
// Rebuilds an Annex B byte stream from RTP packets carrying single NAL units
// and FU-A fragments.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_rtp_depacketizer #(
    parameter int CMD_DEPTH = h264rtp_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] out_byte, [8] unit_end,
                                        // [40:9] unit_timestamp, [47:41] zero
    output logic [2:0]       m_tuser,   // [0] byte_valid, [2:1] error_code
    output logic             m_tlast
);

    h264rtp_pkg::cmd_t push_cmd;
    h264rtp_pkg::cmd_t head_cmd;
    logic              push;
    logic              push_ready;
    logic              pop;
    logic              head_valid;

    assign s_tready = push_ready;

    h264rtp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .cmd_ready (push_ready),
        .cmd       (push_cmd),
        .cmd_push  (push)
    );

    h264rtp_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid)
    );

    h264rtp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/tb_h264_rtp_depacketizer.sv =====
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer testbench
// Streams RTP packets into the block one byte per beat: a directed set of
// single NAL, FU-A, short, bad-version and unsupported-type packets, then
// random access units split into FU-A fragments with noise and broken
// packets mixed in. An in-bench predictor rebuilds the Annex B stream from
// every accepted byte, and each result beat is compared field by field
// against it. Runs under four mixes of source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_h264_rtp_depacketizer;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rtp_byte_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        valid;
        logic        eou;
        logic [31:0] ts;
        logic [1:0]  err;
        logic        last;
    } au_beat_t;

    localparam int QUIET_LIMIT  = 1000;
    localparam int PHASE_BYTES  = 75;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    h264_rtp_depacketizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    rtp_byte_t   pending[$];
    logic [7:0]  pkt[$];
    au_beat_t    au_expect[$];
    au_beat_t    step_beats[$];

    int          send_idle = 0;
    int          recv_stall = 0;
    logic        s_fire = 1'b0;
    int          quiet = 0;
    int          fails = 0;
    int          bytes_queued = 0;
    int          packets = 0;
    int          beats_checked = 0;
    int          error_beats = 0;
    logic [31:0] cur_ts = 32'h0;

    // depacketizer state
    logic [3:0]  rtp_pos = 4'd0;
    logic        drop_pkt = 1'b0;
    logic        marker_bit = 1'b0;
    logic [31:0] ts_gather = 32'h0;
    logic [31:0] unit_ts = 32'h0;
    logic        au_open = 1'b0;
    logic        in_fu = 1'b0;
    logic [1:0]  nri = 2'b00;

    function automatic void emit(input logic [7:0] d, input logic v, input logic e,
                                 input logic [1:0] c);
        step_beats.push_back('{d, v, e, unit_ts, c, 1'b0});
    endfunction

    function automatic void emit_start_code();
        emit(8'h00, 1'b1, 1'b0, h264rtp_pkg::ERR_NONE);
        emit(8'h00, 1'b1, 1'b0, h264rtp_pkg::ERR_NONE);
        emit(8'h00, 1'b1, 1'b0, h264rtp_pkg::ERR_NONE);
        emit(8'h01, 1'b1, 1'b0, h264rtp_pkg::ERR_NONE);
    endfunction

    task automatic depacketize(input logic [7:0] b, input logic last);
        logic [4:0] nal;
        logic       close;
        step_beats.delete();
        if (rtp_pos < h264rtp_pkg::POS_HDR_END) begin
            if (rtp_pos == h264rtp_pkg::POS_FIRST)
                drop_pkt = (b & h264rtp_pkg::VER_MASK) != h264rtp_pkg::VER_TWO;
            if (rtp_pos == h264rtp_pkg::POS_FLAGS)
                marker_bit = b[7];
            if (rtp_pos >= h264rtp_pkg::POS_TS_LO && rtp_pos <= h264rtp_pkg::POS_TS_HI)
                ts_gather = {ts_gather[23:0], b};
            if (last)
                emit(8'h00, 1'b0, 1'b0, h264rtp_pkg::ERR_SHORT);
        end else if (rtp_pos == h264rtp_pkg::POS_HDR_END) begin
            if (drop_pkt) begin
                emit(8'h00, 1'b0, 1'b0, h264rtp_pkg::ERR_VERSION);
            end else begin
                nal = b[4:0];
                if (ts_gather != unit_ts) begin
                    // close the open unit under its old timestamp
                    if (au_open) begin
                        emit(8'h00, 1'b0, 1'b1, h264rtp_pkg::ERR_NONE);
                        au_open = 1'b0;
                    end
                    unit_ts = ts_gather;
                end
                if (nal <= h264rtp_pkg::NAL_SINGLE_MAX) begin
                    in_fu = 1'b0;
                    emit_start_code();
                    emit(b, 1'b1, last, h264rtp_pkg::ERR_NONE);
                    au_open = !last;
                end else if (nal == h264rtp_pkg::NAL_FU_A) begin
                    in_fu = 1'b1;
                    nri = b[6:5];
                    if (last)
                        emit(8'h00, 1'b0, 1'b0, h264rtp_pkg::ERR_SHORT);
                end else begin
                    drop_pkt = 1'b1;
                    emit(8'h00, 1'b0, 1'b0, h264rtp_pkg::ERR_NAL_TYPE);
                end
            end
        end else if (!drop_pkt) begin
            if (!in_fu) begin
                emit(b, 1'b1, last, h264rtp_pkg::ERR_NONE);
                au_open = !last;
            end else if (rtp_pos == h264rtp_pkg::POS_FU_HDR) begin
                if (b[7] || !au_open) begin
                    emit_start_code();
                    emit({1'b0, nri, b[4:0]}, 1'b1, 1'b0, h264rtp_pkg::ERR_NONE);
                    au_open = 1'b1;
                end
                if (last && marker_bit) begin
                    if (step_beats.size() > 0)
                        step_beats[step_beats.size() - 1].eou = 1'b1;
                    else
                        emit(8'h00, 1'b0, 1'b1, h264rtp_pkg::ERR_NONE);
                    au_open = 1'b0;
                end
            end else begin
                close = last && marker_bit;
                emit(b, 1'b1, close, h264rtp_pkg::ERR_NONE);
                if (close)
                    au_open = 1'b0;
            end
        end
        if (last) begin
            rtp_pos = 4'd0;
            drop_pkt = 1'b0;
        end else if (rtp_pos < h264rtp_pkg::POS_SAT) begin
            rtp_pos = rtp_pos + 4'd1;
        end
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
        foreach (step_beats[i])
            au_expect.push_back(step_beats[i]);
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
            fails++;
        end
    endtask

    task automatic check_beat();
        au_beat_t want;
        au_beat_t got;
        got = {m_tdata[7:0], m_tuser[0], m_tdata[8], m_tdata[40:9], m_tuser[2:1], m_tlast};
        if (au_expect.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual 0x%0h", $time, got);
            fails++;
            return;
        end
        want = au_expect.pop_front();
        beats_checked++;
        if (got.err != h264rtp_pkg::ERR_NONE)
            error_beats++;
        compare_field("out_byte", 32'(want.data), 32'(got.data));
        compare_field("byte_valid", 32'(want.valid), 32'(got.valid));
        compare_field("unit_end", 32'(want.eou), 32'(got.eou));
        compare_field("unit_timestamp", want.ts, got.ts);
        compare_field("error_code", 32'(want.err), 32'(got.err));
        compare_field("run_last", 32'(want.last), 32'(got.last));
    endtask

    always @(posedge aclk) begin
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready)
                check_beat();
            if (s_tvalid && s_tready)
                depacketize(s_tdata, s_tlast);
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (s_fire)
                void'(pending.pop_front());
            if (pending.size() != 0 && $urandom_range(99) >= send_idle) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending[0].data;
                s_tlast <= pending[0].last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic header(input logic [31:0] ts, input logic mark, input logic good);
        logic [1:0] ver;
        ver = 2'($urandom_range(2));
        if (ver == 2'b10)
            ver = 2'b11;
        if (good)
            ver = 2'b10;
        pkt.delete();
        pkt.push_back({ver, 6'($urandom)});
        pkt.push_back({mark, 7'($urandom)});
        repeat (2) pkt.push_back(8'($urandom));
        for (int i = 3; i >= 0; i--)
            pkt.push_back(ts[8*i +: 8]);
        repeat (4) pkt.push_back(8'($urandom));
    endtask

    task automatic payload(input int n);
        repeat (n) pkt.push_back(8'($urandom));
    endtask

    task automatic flush_packet();
        foreach (pkt[i])
            pending.push_back('{pkt[i], i == pkt.size() - 1});
        bytes_queued += pkt.size();
        packets++;
    endtask

    task automatic random_traffic(input int budget);
        int stop;
        int kind;
        int frags;
        int n;
        int t;
        stop = bytes_queued + budget;
        while (bytes_queued < stop) begin
            if ($urandom_range(1) != 0)
                cur_ts = ($urandom_range(3) == 0) ? $urandom : cur_ts + 32'd3000;
            kind = $urandom_range(99);
            if (kind < 45) begin
                // one access unit split into FU-A fragments
                frags = $urandom_range(1, 4);
                for (int f = 0; f < frags; f++) begin
                    header(cur_ts, f == frags - 1 && $urandom_range(4) != 0, 1'b1);
                    pkt.push_back({1'($urandom), 2'($urandom), h264rtp_pkg::NAL_FU_A});
                    if ($urandom_range(9) != 0) begin
                        pkt.push_back({f == 0 && $urandom_range(7) != 0, f == frags - 1,
                                       1'($urandom), 5'($urandom)});
                        payload($urandom_range(0, 5));
                    end
                    flush_packet();
                end
            end else if (kind < 70) begin
                header(cur_ts, 1'($urandom), 1'b1);
                pkt.push_back({3'($urandom), 5'($urandom_range(0, 23))});
                payload($urandom_range(0, 7));
                flush_packet();
            end else if (kind < 78) begin
                t = $urandom_range(24, 30);
                if (t >= 28)
                    t++;
                header(cur_ts, 1'($urandom), 1'b1);
                pkt.push_back({3'($urandom), 5'(t)});
                payload($urandom_range(0, 4));
                flush_packet();
            end else if (kind < 85) begin
                header(cur_ts, 1'($urandom), 1'b0);
                payload($urandom_range(0, 6));
                flush_packet();
            end else if (kind < 92) begin
                n = $urandom_range(1, 12);
                header(cur_ts, 1'($urandom), 1'b1);
                while (pkt.size() > n)
                    void'(pkt.pop_back());
                flush_packet();
            end else begin
                pkt.delete();
                payload($urandom_range(1, 20));
                flush_packet();
            end
        end
    endtask

    task automatic drain();
        while (pending.size() != 0 || au_expect.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        header(32'h0102_0304, 1'b0, 1'b1);
        pkt.push_back(8'h65);
        flush_packet();
        header(32'h0102_0304, 1'b1, 1'b1);
        pkt.push_back(8'h41); pkt.push_back(8'h00); pkt.push_back(8'hff);
        flush_packet();
        header(32'hffff_ffff, 1'b0, 1'b1);
        pkt.push_back(8'hfc); pkt.push_back(8'h85); pkt.push_back(8'hab);
        pkt.push_back(8'h54);
        flush_packet();
        header(32'hffff_ffff, 1'b0, 1'b1);
        pkt.push_back(8'h7c); pkt.push_back(8'h05); pkt.push_back(8'h12);
        flush_packet();
        header(32'hffff_ffff, 1'b0, 1'b1);
        pkt.push_back(8'h5c); pkt.push_back(8'h85);
        flush_packet();
        header(32'h0, 1'b0, 1'b1);
        pkt.push_back(8'h06); pkt.push_back(8'h01);
        flush_packet();
        header(32'h0, 1'b1, 1'b1);
        pkt.push_back(8'h1c); pkt.push_back(8'h45); pkt.push_back(8'hff);
        flush_packet();
        header(32'h0, 1'b1, 1'b1);
        pkt.push_back(8'h3c); pkt.push_back(8'h85);
        flush_packet();
        header(32'h0, 1'b1, 1'b1);
        pkt.push_back(8'h7c);
        flush_packet();
        header(32'h0, 1'b0, 1'b1);
        flush_packet();
        pkt.delete();
        pkt.push_back(8'h80);
        flush_packet();
        header(32'h5, 1'b0, 1'b0);
        pkt.push_back(8'h65); pkt.push_back(8'h11);
        flush_packet();
        header(32'h5, 1'b0, 1'b0);
        while (pkt.size() > 5)
            void'(pkt.pop_back());
        flush_packet();
        header(32'h7, 1'b0, 1'b1);
        pkt.push_back(8'h18); pkt.push_back(8'h00);
        flush_packet();
        header(32'h7, 1'b0, 1'b1);
        pkt.push_back(8'hff);
        flush_packet();
        cur_ts = 32'h7;

        random_traffic(PHASE_BYTES);
        drain();
        send_idle = 85;
        random_traffic(PHASE_BYTES);
        drain();
        send_idle = 0;
        recv_stall = 85;
        random_traffic(PHASE_BYTES);
        drain();
        send_idle = 8;
        recv_stall = 8;
        random_traffic(PHASE_BYTES);
        drain();

        repeat (20) @(posedge aclk);
        $display("Streamed %0d bytes in %0d packets under four gap/back-pressure mixes;",
                 bytes_queued, packets);
        $display("checked %0d result beats, %0d of them error reports.",
                 beats_checked, error_beats);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
